@@ rtl/core/qses_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qses_pkg
// Shared widths, codes and register defaults of the wheel speed estimator.
// ----------------------------------------------------------------------------
package qses_pkg;

   // channel count and field widths
   localparam int NUM_CH     = 4;
   localparam int CH_W       = 2;
   localparam int STAMP_W    = 16;
   localparam int SPEED_W    = 32;
   localparam int PERIOD_W   = 16;
   localparam int FRAC_W     = 8;
   localparam int DIVIDEND_W = PERIOD_W + FRAC_W;
   localparam int CSR_IDX_W  = 2;

   // request codes
   localparam logic [1:0] REQ_FWD  = 2'd0;
   localparam logic [1:0] REQ_REV  = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   // speed method codes
   localparam logic [1:0] METH_FWD   = 2'd0;
   localparam logic [1:0] METH_REV   = 2'd1;
   localparam logic [1:0] METH_COUNT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUMERATOR  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE      = 2'd3;

   // register reset values
   localparam logic [15:0] RST_IDLE_LIMIT = 16'd100;
   localparam logic [15:0] RST_THRESHOLD  = 16'd320;
   localparam logic [15:0] RST_NUMERATOR  = 16'd60000;
   localparam logic [15:0] RST_SCALE      = 16'd48000;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EVAL = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ rtl/core/qses_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qses_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qses_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [qses_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [qses_pkg::PERIOD_W-1:0]      divisor,
   output qses_pkg::div_status_type           status,
   output logic [qses_pkg::DIVIDEND_W-1:0]    quotient
);
   import qses_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [PERIOD_W-1:0]   rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [PERIOD_W-1:0]   dsr_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff, done_ff;
   logic [PERIOD_W:0]     trial, diff;
   logic                  fits;

   // one restoring step
   always_comb begin
      trial   = {rem_ff, quot_ff[DIVIDEND_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = trial >= {1'b0, dsr_ff};
      rem_in  = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
   end

   // iteration control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quot_ff <= dividend;
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

endmodule

@@ rtl/core/quad_encoder_speed_estimator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_encoder_speed_estimator_top
// Four-channel wheel speed estimator, period and count methods.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: an edge item (forward or reverse) with channel and timestamp
//    updates that channel's count and period in the cycle it is taken.
//  - a tick item starts a pass over all channels; one rsp item per channel in
//    channel order, rsp_last set on the final channel.
//  - per channel: an evaluation step, then either a run of the shared 24-step
//    divider (period method) or no division (count method), then a step to
//    load the output register.
//  - the single shared divider and rsp_stall set the tick time.
//  - req_stall is high for the whole tick pass.
//  - rsp_stall holds the output register; the pass waits at the load step.
//  - csr channel: always ready, writes are meant only while the block is idle.
//  - synchronous reset clears all channel state and loads register defaults.
// ----------------------------------------------------------------------------
module quad_encoder_speed_estimator_top (
   input  logic                              clock,
   input  logic                              reset,
   // input items
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic [qses_pkg::CH_W-1:0]         req_channel,
   input  logic [qses_pkg::STAMP_W-1:0]      req_timestamp,
   // result items
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [qses_pkg::CH_W-1:0]         rsp_out_channel,
   output logic signed [qses_pkg::SPEED_W-1:0] rsp_speed_q8,
   output logic [1:0]                        rsp_method,
   output logic                              rsp_last,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [qses_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [15:0]                       csr_wdata
);
   import qses_pkg::*;

   // configuration registers
   logic [15:0] idle_limit_ff, threshold_ff, numerator_ff, scale_ff;

   // channel state
   logic [15:0] edge_count_ff [NUM_CH];
   logic [15:0] count_at_tick_ff [NUM_CH];
   logic [15:0] fwd_stamp_ff [NUM_CH];
   logic [15:0] rev_stamp_ff [NUM_CH];
   logic [15:0] fwd_period_ff [NUM_CH];
   logic [15:0] rev_period_ff [NUM_CH];
   logic [15:0] idle_ticks_ff [NUM_CH];

   // sequencer and result
   state_type           state_ff, state_in;
   logic [CH_W-1:0]     ch_ff;
   logic [1:0]          method_ff;
   logic [SPEED_W-1:0]  speed_ff;

   // output register
   logic                rsp_valid_ff;
   logic [CH_W-1:0]     rsp_channel_ff;
   logic [SPEED_W-1:0]  rsp_speed_ff;
   logic [1:0]          rsp_method_ff;
   logic                rsp_last_ff;

   // divider
   logic                  div_start;
   logic [PERIOD_W-1:0]   div_divisor;
   div_status_type        div_status;
   logic [DIVIDEND_W-1:0] div_quotient;

   logic req_take, edge_go, ch_ok, is_fwd, last_ch, out_free;
   logic [15:0] edge_in, period_in;
   logic [15:0] du, idle_inc, idle_in, fwd_eval, rev_eval;
   logic        clear_periods, use_fwd, use_rev;
   logic signed [32:0] count_prod;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign ch_ok     = 32'(req_channel) < NUM_CH;
   assign is_fwd    = (req_type == REQ_FWD);
   assign edge_go   = req_take && (req_type == REQ_FWD || req_type == REQ_REV) && ch_ok;
   assign last_ch   = (ch_ff == CH_W'(NUM_CH - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // edge update of the addressed channel
   always_comb begin
      if (is_fwd) begin
         edge_in   = edge_count_ff[req_channel] + 16'd1;
         period_in = req_timestamp - fwd_stamp_ff[req_channel];
      end else begin
         edge_in   = edge_count_ff[req_channel] - 16'd1;
         period_in = req_timestamp - rev_stamp_ff[req_channel];
      end
   end

   // tick evaluation of the current channel
   always_comb begin
      du            = edge_count_ff[ch_ff] - count_at_tick_ff[ch_ff];
      idle_inc      = idle_ticks_ff[ch_ff] + 16'd1;
      clear_periods = (du == 16'd0) && (idle_inc == idle_limit_ff);
      idle_in       = (du != 16'd0 || clear_periods) ? 16'd0 : idle_inc;
      fwd_eval      = clear_periods ? 16'd0 : fwd_period_ff[ch_ff];
      rev_eval      = clear_periods ? 16'd0 : rev_period_ff[ch_ff];
      use_fwd       = (fwd_eval != 16'd0) && (fwd_eval >= threshold_ff);
      use_rev       = (rev_eval != 16'd0) && (rev_eval >= threshold_ff);
      count_prod    = $signed({1'b0, scale_ff}) * $signed(du);
      div_divisor   = use_fwd ? fwd_eval : rev_eval;
      div_start     = (state_ff == ST_EVAL) && (use_fwd || use_rev);
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_limit_ff <= RST_IDLE_LIMIT;
         threshold_ff  <= RST_THRESHOLD;
         numerator_ff  <= RST_NUMERATOR;
         scale_ff      <= RST_SCALE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IDLE_LIMIT: idle_limit_ff <= csr_wdata;
            CSR_THRESHOLD:  threshold_ff  <= csr_wdata;
            CSR_NUMERATOR:  numerator_ff  <= csr_wdata;
            CSR_SCALE:      scale_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // channel state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) begin
            edge_count_ff[i]    <= '0;
            count_at_tick_ff[i] <= '0;
            fwd_stamp_ff[i]     <= '0;
            rev_stamp_ff[i]     <= '0;
            fwd_period_ff[i]    <= '0;
            rev_period_ff[i]    <= '0;
            idle_ticks_ff[i]    <= '0;
         end
      end else if (edge_go) begin
         edge_count_ff[req_channel] <= edge_in;
         if (is_fwd) begin
            fwd_period_ff[req_channel] <= period_in;
            fwd_stamp_ff[req_channel]  <= req_timestamp;
         end else begin
            rev_period_ff[req_channel] <= period_in;
            rev_stamp_ff[req_channel]  <= req_timestamp;
         end
      end else if (state_ff == ST_EVAL) begin
         count_at_tick_ff[ch_ff] <= edge_count_ff[ch_ff];
         idle_ticks_ff[ch_ff]    <= idle_in;
         fwd_period_ff[ch_ff]    <= fwd_eval;
         rev_period_ff[ch_ff]    <= rev_eval;
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_take && req_type == REQ_TICK) state_in = ST_EVAL;
         ST_EVAL: state_in = (use_fwd || use_rev) ? ST_DIV : ST_EMIT;
         ST_DIV:  if (div_status.done) state_in = ST_EMIT;
         ST_EMIT: if (out_free) state_in = last_ch ? ST_IDLE : ST_EVAL;
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ch_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE) begin
            ch_ff <= '0;
         end else if (state_ff == ST_EMIT && out_free) begin
            ch_ff <= ch_ff + 1'b1;
         end
      end
   end

   // speed and method of the current channel
   always_ff @(posedge clock) begin
      if (state_ff == ST_EVAL) begin
         if (use_fwd) begin
            method_ff <= METH_FWD;
         end else if (use_rev) begin
            method_ff <= METH_REV;
         end else begin
            method_ff <= METH_COUNT;
            speed_ff  <= count_prod[SPEED_W-1:0];
         end
      end else if (state_ff == ST_DIV && div_status.done) begin
         if (method_ff == METH_FWD) begin
            speed_ff <= SPEED_W'(div_quotient);
         end else begin
            speed_ff <= SPEED_W'(0) - SPEED_W'(div_quotient);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_EMIT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && out_free) begin
         rsp_channel_ff <= ch_ff;
         rsp_speed_ff   <= speed_ff;
         rsp_method_ff  <= method_ff;
         rsp_last_ff    <= last_ch;
      end
   end

   // shared divider
   qses_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({numerator_ff, FRAC_W'(0)}),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_channel_ff;
   assign rsp_speed_q8    = $signed(rsp_speed_ff);
   assign rsp_method      = rsp_method_ff;
   assign rsp_last        = rsp_last_ff;

   // checks
   a_last_on_final_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_out_channel == CH_W'(NUM_CH - 1))
      else $error("last flag on a channel other than the final one");

   a_fwd_speed_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_method == METH_FWD |-> !rsp_speed_q8[SPEED_W-1])
      else $error("forward period speed is negative");

   a_div_running: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_status.busy || div_status.done)
      else $error("waiting on a divider that is not running");

   a_tick_starts_pass: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == REQ_TICK |=> state_ff == ST_EVAL && ch_ff == '0)
      else $error("tick item did not start a channel pass");

endmodule

@@ tb/sv/tb_quad_encoder_speed_estimator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quad_encoder_speed_estimator_top
// Self-checking bench for the four-channel wheel speed estimator. A queue-fed
// driver offers edge, tick and unknown items while the receiver stalls at
// random. A per-channel speed predictor computes the four results of every
// tick, and each returned result is checked field by field against it.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_quad_encoder_speed_estimator_top;
   import qses_pkg::*;

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int         HOLD_CYCLES = 400;
   localparam int         SETTLE_CYCLES = 120;

   typedef struct {
      logic [1:0]         kind;
      logic [CH_W-1:0]    ch;
      logic [STAMP_W-1:0] stamp;
   } enc_item_t;

   typedef struct {
      logic [CH_W-1:0]           ch;
      logic signed [SPEED_W-1:0] speed;
      logic [1:0]                method;
      logic                      last;
   } speed_rec_t;

   // dut ports
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_type = REQ_FWD;
   logic [CH_W-1:0]           req_channel = '0;
   logic [STAMP_W-1:0]        req_timestamp = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [CH_W-1:0]           rsp_out_channel;
   logic signed [SPEED_W-1:0] rsp_speed_q8;
   logic [1:0]                rsp_method;
   logic                      rsp_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_IDLE_LIMIT;
   logic [15:0]               csr_wdata = '0;

   // predictor registers and per-channel state
   logic [15:0] idle_limit_m, threshold_m, numerator_m, scale_m;
   logic [15:0] count_m[NUM_CH];
   logic [15:0] count_tick_m[NUM_CH];
   logic [15:0] fwd_stamp_m[NUM_CH];
   logic [15:0] rev_stamp_m[NUM_CH];
   logic [15:0] fwd_per_m[NUM_CH];
   logic [15:0] rev_per_m[NUM_CH];
   logic [15:0] idle_m[NUM_CH];

   enc_item_t   pend_q[$];
   speed_rec_t  speed_q[$];
   int          n_sent = 0;
   int          n_taken = 0;
   int          n_errors = 0;
   int          send_gap_pct = 36;
   int          recv_gap_pct = 53;
   int          hold_asked = 0;
   int          hold_taken = 0;
   int          hold_left = 0;
   bit          req_took = 1'b0;
   logic [15:0] chan_stamp[NUM_CH];

   quad_encoder_speed_estimator_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_channel     (req_channel),
      .req_timestamp   (req_timestamp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_speed_q8    (rsp_speed_q8),
      .rsp_method      (rsp_method),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   // a zero period never selects the period method
   function automatic bit period_ok(logic [15:0] p);
      return p != 16'd0 && p >= threshold_m;
   endfunction

   function automatic logic [31:0] period_quot(logic [15:0] p);
      logic [23:0] num;
      num = {numerator_m, 8'h00};
      return 32'(num / p);
   endfunction

   // advance the channel state by one accepted item, queue any speeds
   task automatic update_speed_model(enc_item_t it);
      logic [15:0] du;
      int          d;
      speed_rec_t  r;
      case (it.kind)
         REQ_FWD: begin
            count_m[it.ch]     = count_m[it.ch] + 16'd1;
            fwd_per_m[it.ch]   = it.stamp - fwd_stamp_m[it.ch];
            fwd_stamp_m[it.ch] = it.stamp;
         end
         REQ_REV: begin
            count_m[it.ch]     = count_m[it.ch] - 16'd1;
            rev_per_m[it.ch]   = it.stamp - rev_stamp_m[it.ch];
            rev_stamp_m[it.ch] = it.stamp;
         end
         REQ_TICK: begin
            for (int c = 0; c < NUM_CH; c++) begin
               du = count_m[c] - count_tick_m[c];
               d  = $signed(du);
               // idle tracking, periods clear when the limit is hit
               if (du == 16'd0) begin
                  idle_m[c] = idle_m[c] + 16'd1;
                  if (idle_m[c] == idle_limit_m) begin
                     fwd_per_m[c] = '0;
                     rev_per_m[c] = '0;
                     idle_m[c]    = '0;
                  end
               end else begin
                  idle_m[c] = '0;
               end
               count_tick_m[c] = count_m[c];
               r.ch   = CH_W'(c);
               r.last = (c == NUM_CH - 1);
               if (period_ok(fwd_per_m[c])) begin
                  r.speed  = period_quot(fwd_per_m[c]);
                  r.method = METH_FWD;
               end else if (period_ok(rev_per_m[c])) begin
                  r.speed  = -period_quot(rev_per_m[c]);
                  r.method = METH_REV;
               end else begin
                  r.speed  = 32'(longint'(scale_m) * d);
                  r.method = METH_COUNT;
               end
               speed_q.push_back(r);
            end
         end
         default: ;
      endcase
   endtask

   // compare one returned speed with the oldest prediction
   task automatic check_speed();
      speed_rec_t want;
      if (speed_q.size() == 0) begin
         $error("unexpected result: channel %0d speed %0d", rsp_out_channel, rsp_speed_q8);
         n_errors++;
      end else begin
         want = speed_q.pop_front();
         if (rsp_out_channel !== want.ch) begin
            $error("out_channel mismatch: expected %0d, got %0d", want.ch, rsp_out_channel);
            n_errors++;
         end
         if (rsp_speed_q8 !== want.speed) begin
            $error("speed_q8 mismatch: expected %0d, got %0d", want.speed, rsp_speed_q8);
            n_errors++;
         end
         if (rsp_method !== want.method) begin
            $error("method mismatch: expected %0d, got %0d", want.method, rsp_method);
            n_errors++;
         end
         if (rsp_last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, rsp_last);
            n_errors++;
         end
      end
   endtask

   // input driver, fed from the pending queue
   always @(negedge clock) begin : drive_blk
      enc_item_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pend_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            nxt = pend_q.pop_front();
            req_valid     <= 1'b1;
            req_type      <= nxt.kind;
            req_channel   <= nxt.ch;
            req_timestamp <= nxt.stamp;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, random or one long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_taken != hold_asked) begin
         hold_taken++;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_gap_pct);
      end
   end

   // monitor: accepted items feed the predictor, results are checked
   always @(posedge clock) begin : mon_blk
      enc_item_t seen;
      if (reset) begin
         req_took = 1'b0;
      end else begin
         req_took = req_valid && !req_stall;
         if (req_took) begin
            seen.kind  = req_type;
            seen.ch    = req_channel;
            seen.stamp = req_timestamp;
            n_taken++;
            update_speed_model(seen);
         end
         if (rsp_valid && !rsp_stall)
            check_speed();
      end
   end

   task automatic push_item(logic [1:0] kind, logic [CH_W-1:0] ch, logic [15:0] stamp);
      enc_item_t it;
      it.kind  = kind;
      it.ch    = ch;
      it.stamp = stamp;
      pend_q.push_back(it);
      n_sent++;
   endtask

   // time between edges, mostly up to 1023, sometimes zero or any 16-bit value
   function automatic logic [15:0] next_gap();
      int r;
      r = $urandom_range(99);
      if (r < 10)
         return 16'd0;
      if (r < 25)
         return 16'($urandom);
      return 16'($urandom_range(1023));
   endfunction

   // bursts of edges on one channel and ticks, with some noise mixed in
   task automatic add_random(int n);
      int         made;
      int         r;
      int         c;
      logic [1:0] dir;
      made = 0;
      while (made < n) begin
         r = $urandom_range(99);
         if (r < 6) begin
            push_item(REQ_UNKNOWN, CH_W'($urandom), 16'($urandom));
         end else if (r < 18) begin
            push_item(REQ_TICK, CH_W'($urandom), 16'($urandom));
            made++;
         end else if (r < 26) begin
            dir = $urandom_range(1) ? REQ_REV : REQ_FWD;
            push_item(dir, CH_W'($urandom), 16'($urandom));
            made++;
         end else begin
            c   = $urandom_range(NUM_CH - 1);
            dir = $urandom_range(1) ? REQ_REV : REQ_FWD;
            repeat ($urandom_range(1, 6)) begin
               chan_stamp[c] = chan_stamp[c] + next_gap();
               push_item(dir, CH_W'(c), chan_stamp[c]);
               made++;
            end
            if ($urandom_range(1)) begin
               push_item(REQ_TICK, '0, '0);
               made++;
            end
         end
      end
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_IDLE_LIMIT: idle_limit_m = val;
         CSR_THRESHOLD:  threshold_m  = val;
         CSR_NUMERATOR:  numerator_m  = val;
         CSR_SCALE:      scale_m      = val;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [15:0] lim, logic [15:0] thr, logic [15:0] num,
                             logic [15:0] scl);
      csr_write(CSR_IDLE_LIMIT, lim);
      csr_write(CSR_THRESHOLD, thr);
      csr_write(CSR_NUMERATOR, num);
      csr_write(CSR_SCALE, scl);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // all items taken and every speed returned, then let the block settle
   task automatic wait_quiet();
      do @(negedge clock); while (n_taken != n_sent || speed_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // stimulus
   initial begin
      idle_limit_m = RST_IDLE_LIMIT;
      threshold_m  = RST_THRESHOLD;
      numerator_m  = RST_NUMERATOR;
      scale_m      = RST_SCALE;
      for (int c = 0; c < NUM_CH; c++) begin
         count_m[c]      = '0;
         count_tick_m[c] = '0;
         fwd_stamp_m[c]  = '0;
         rev_stamp_m[c]  = '0;
         fwd_per_m[c]    = '0;
         rev_per_m[c]    = '0;
         idle_m[c]       = '0;
         chan_stamp[c]   = '0;
      end
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at reset register values
      push_item(REQ_TICK, 2'd0, 16'd0);          // all channels at rest
      push_item(REQ_FWD, 2'd0, 16'd0);           // zero period
      push_item(REQ_FWD, 2'd0, 16'd1000);        // forward period method
      push_item(REQ_REV, 2'd1, 16'hFFFF);        // largest period
      push_item(REQ_REV, 2'd1, 16'd100);         // timestamp wraps
      push_item(REQ_FWD, 2'd2, 16'd400);
      push_item(REQ_FWD, 2'd2, 16'd700);         // below threshold, count method
      push_item(REQ_REV, 2'd3, 16'd0);           // count wraps below zero
      push_item(REQ_UNKNOWN, 2'd3, 16'hFFFF);    // ignored request
      push_item(REQ_TICK, 2'd3, 16'hFFFF);
      push_item(REQ_REV, 2'd0, 16'd2000);        // stale forward period still wins
      push_item(REQ_FWD, 2'd1, 16'hFFFF);
      push_item(REQ_FWD, 2'd3, 16'd320);         // period equal to threshold
      push_item(REQ_TICK, 2'd1, 16'd0);
      push_item(REQ_TICK, 2'd2, 16'd0);          // idle ticks
      push_item(REQ_UNKNOWN, 2'd0, 16'd0);
      push_item(REQ_TICK, 2'd0, 16'd0);
      wait_quiet();

      // short idle limit, zero threshold, largest numerator and scale
      set_config(16'd3, 16'd0, 16'hFFFF, 16'hFFFF);
      hold_asked++;
      add_random(140);
      wait_quiet();

      // swapped idling, largest limit and threshold, numerator of one and zero scale
      send_gap_pct = 53;
      recv_gap_pct = 36;
      set_config(16'hFFFF, 16'hFFFF, 16'd1, 16'd0);
      hold_asked++;
      add_random(140);
      wait_quiet();

      // no idling on either side
      send_gap_pct = 0;
      recv_gap_pct = 0;
      set_config(16'd1, 16'd200, 16'd60000, 16'd48000);
      add_random(140);
      wait_quiet();

      // zero idle limit, and a long run of reverse edges before one tick
      set_config(16'd0, 16'hFFFF, 16'd12345, 16'hFFFF);
      for (int i = 1; i <= 40; i++)
         push_item(REQ_REV, 2'd2, 16'(i));
      push_item(REQ_TICK, 2'd0, 16'd0);
      add_random(20);
      wait_quiet();

      if (n_errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ quad_encoder_speed_estimator_top.f @@
rtl/core/qses_pkg.sv
rtl/core/qses_div.sv
rtl/core/quad_encoder_speed_estimator_top.sv
tb/sv/tb_quad_encoder_speed_estimator_top.sv
